// ===== rtl/core/ptil_pkg.sv =====
// Shared types and constants for the prefix tree insert/lookup unit.
// No dependencies; the interfaces and the top unit use this package, ptil_ram does not.
package ptil_pkg;

  // Widths of the fixed item fields
  localparam int unsigned FUNC_W   = 2;
  localparam int unsigned LETTER_W = 5;

  // Operation codes carried in func; the unused code walks like a prefix search
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_PREFIX = 2'd2;

  // One input word as held during its walk step
  typedef struct packed {
    logic [FUNC_W-1:0]   func;
    logic [LETTER_W-1:0] letter;
    logic                has_letter;
    logic                last;
  } in_word_t;

  // Walk sequencer states, one-hot
  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_LOOK  = 4'b0010,
    S_ALLOC = 4'b0100,
    S_FIN   = 4'b1000
  } state_e;

endpackage

// ===== rtl/core/ptil_if.sv =====
// Valid/ready channel interfaces for the letter input and the result output.
// Depends on ptil_pkg for the field widths.
interface ptil_in_if;
  logic                             valid;
  logic                             ready;
  logic [ptil_pkg::FUNC_W-1:0]      func;
  logic [ptil_pkg::LETTER_W-1:0]    letter;
  logic                             has_letter;
  logic                             last;

  modport source (output valid, func, letter, has_letter, last, input ready);
  modport sink   (input valid, func, letter, has_letter, last, output ready);
endinterface

interface ptil_out_if;
  logic valid;
  logic ready;
  logic found;
  logic status;

  modport source (output valid, found, status, input ready);
  modport sink   (input valid, found, status, output ready);
endinterface

// ===== rtl/core/ptil_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies; contents are undefined until written.
module ptil_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/prefix_tree_insert_lookup_unit.sv =====
// Prefix tree insert/lookup unit: a closing letter word's result is registered
// after the look and close (or allocate) states, later only while an earlier
// result waits. The next letter is taken only in the idle state, once the
// registered read of the node row and child slot memories gives the next node;
// allocating or closing letters also pass the allocate or close state. Reset
// clears the walk state, the free pointer (to node 1) and the root row valid bit.
module prefix_tree_insert_lookup_unit #(
  parameter int unsigned MAX_NODES = 1024,
  parameter int unsigned ALPHABET  = 26
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptil_in_if.sink     in_i,
  ptil_out_if.source  out_o
);
  import ptil_pkg::*;

  localparam int unsigned NODE_W = $clog2(MAX_NODES);
  localparam int unsigned FREE_W = $clog2(MAX_NODES + 1);
  localparam int unsigned SLOTS  = MAX_NODES * ALPHABET;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned ROW_W  = ALPHABET + 1;   // {word_end, child_present}

  state_e              state_q, state_d;
  in_word_t            item_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [NODE_W-1:0]   current_node_q, current_node_d;
  logic [FREE_W-1:0]   next_free_q, next_free_d;
  logic                failed_q, failed_d;
  logic                root_valid_q, root_valid_d;
  logic                out_valid_q, out_valid_d;
  logic                found_q, found_d;
  logic                status_q, status_d;

  // Memory ports
  logic                row_we;
  logic [NODE_W-1:0]   row_waddr;
  logic [ROW_W-1:0]    row_wdata;
  logic [NODE_W-1:0]   row_raddr;
  logic [ROW_W-1:0]    row_rdata;
  logic                child_we;
  logic [NODE_W-1:0]   child_rdata;
  logic [SLOT_W-1:0]   slot_addr;

  // Walk decode
  logic                in_accept;
  logic                out_free;
  logic [ROW_W-1:0]    row;
  logic [ALPHABET-1:0] present_shift;
  logic [ALPHABET-1:0] letter_mask;
  logic                letter_ok;
  logic                step;
  logic                child_hit;
  logic                pool_ok;
  logic                is_insert;
  logic                is_search;

  assign in_accept = in_i.valid && in_i.ready;
  assign in_i.ready = (state_q == S_IDLE);
  assign out_free  = !out_valid_q || out_o.ready;

  // Child slot address of the incoming letter under the current node
  assign slot_addr = SLOT_W'(current_node_q) * SLOT_W'(ALPHABET) + SLOT_W'(in_i.letter);

  // Row of the node read last cycle; the root reads as empty until first written
  assign row = (current_node_q == '0 && !root_valid_q) ? '0 : row_rdata;

  assign present_shift = row[ALPHABET-1:0] >> item_q.letter;
  assign letter_mask   = ALPHABET'(1) << item_q.letter;
  assign letter_ok     = 32'(item_q.letter) < 32'(ALPHABET);
  assign step          = item_q.has_letter && letter_ok && !failed_q;
  assign child_hit     = present_shift[0];
  assign pool_ok       = next_free_q < FREE_W'(MAX_NODES);
  assign is_insert     = (item_q.func == FUNC_INSERT);
  assign is_search     = (item_q.func == FUNC_SEARCH);

  // Read the row of the node the next step or close will look at
  assign row_raddr = (state_q == S_LOOK) ? current_node_d : current_node_q;

  // Walk sequencer
  always_comb begin
    state_d        = state_q;
    current_node_d = current_node_q;
    next_free_d    = next_free_q;
    failed_d       = failed_q;
    root_valid_d   = root_valid_q;
    out_valid_d    = out_valid_q && !out_o.ready;
    found_d        = found_q;
    status_d       = status_q;
    row_we         = 1'b0;
    row_waddr      = current_node_q;
    row_wdata      = row;
    child_we       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_accept) begin
          state_d = S_LOOK;
        end
      end

      S_LOOK: begin
        state_d = item_q.last ? S_FIN : S_IDLE;
        if (step) begin
          if (child_hit) begin
            current_node_d = child_rdata;
          end else if (is_insert && pool_ok) begin
            // Link a fresh node under the current one
            child_we       = 1'b1;
            row_we         = 1'b1;
            row_wdata      = row | {1'b0, letter_mask};
            current_node_d = next_free_q[NODE_W-1:0];
            next_free_d    = next_free_q + FREE_W'(1);
            state_d        = S_ALLOC;
            if (current_node_q == '0) begin
              root_valid_d = 1'b1;
            end
          end else begin
            failed_d = 1'b1;
          end
        end
      end

      S_ALLOC: begin
        // Clear the fresh node's row; mark it at once when the word ends here
        if (!item_q.last) begin
          row_we    = 1'b1;
          row_wdata = '0;
          state_d   = S_IDLE;
        end else if (out_free) begin
          row_we         = 1'b1;
          row_wdata      = {1'b1, {ALPHABET{1'b0}}};
          out_valid_d    = 1'b1;
          found_d        = 1'b1;
          status_d       = 1'b0;
          current_node_d = '0;
          failed_d       = 1'b0;
          state_d        = S_IDLE;
        end
      end

      S_FIN: begin
        // Close the word: mark on insert, test the end mark on search, report a whole walk otherwise
        if (out_free) begin
          out_valid_d = 1'b1;
          status_d    = 1'b0;
          if (is_insert) begin
            found_d  = !failed_q;
            status_d = failed_q;
            if (!failed_q) begin
              row_we    = 1'b1;
              row_wdata = row | {1'b1, {ALPHABET{1'b0}}};
              if (current_node_q == '0) begin
                root_valid_d = 1'b1;
              end
            end
          end else if (is_search) begin
            found_d = !failed_q && row[ALPHABET];
          end else begin
            found_d = !failed_q;
          end
          current_node_d = '0;
          failed_d       = 1'b0;
          state_d        = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      current_node_q <= '0;
      next_free_q    <= FREE_W'(1);
      failed_q       <= 1'b0;
      root_valid_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      current_node_q <= current_node_d;
      next_free_q    <= next_free_d;
      failed_q       <= failed_d;
      root_valid_q   <= root_valid_d;
      out_valid_q    <= out_valid_d;
    end
  end

  // Payload registers: held word, its child slot, the result word
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      item_q.func       <= in_i.func;
      item_q.letter     <= in_i.letter;
      item_q.has_letter <= in_i.has_letter;
      item_q.last       <= in_i.last;
      slot_q            <= slot_addr;
    end
    found_q  <= found_d;
    status_q <= status_d;
  end

  assign out_o.valid  = out_valid_q;
  assign out_o.found  = found_q;
  assign out_o.status = status_q;

  // Node rows: child present bits and end-of-word mark
  ptil_ram #(
    .WIDTH (ROW_W),
    .DEPTH (MAX_NODES)
  ) u_row_ram (
    .clk_i   (clk_i),
    .we_i    (row_we),
    .waddr_i (row_waddr),
    .wdata_i (row_wdata),
    .raddr_i (row_raddr),
    .rdata_o (row_rdata)
  );

  // Child node numbers, one slot per node and letter
  ptil_ram #(
    .WIDTH (NODE_W),
    .DEPTH (SLOTS)
  ) u_child_ram (
    .clk_i   (clk_i),
    .we_i    (child_we),
    .waddr_i (slot_q),
    .wdata_i (next_free_q[NODE_W-1:0]),
    .raddr_i (slot_addr),
    .rdata_o (child_rdata)
  );

`ifndef SYNTH
  // The walk only ever stands on the root or an allocated node
  a_node_allocated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FREE_W'(current_node_q) < next_free_q)
    else $error("current node beyond allocated pool");

  // The free pointer never passes the pool size
  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= FREE_W'(MAX_NODES))
    else $error("free pointer past pool size");

  // A result appears only after a close or a closing allocation
  a_result_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_ALLOC || state_q == S_FIN))
    else $error("result without closing step");

  // Closing a word returns the walk to a clean root
  a_walk_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_free) |=> (current_node_q == '0 && !failed_q))
    else $error("walk not returned to root");

  // A full pool never reports a stored word
  a_full_not_found: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q) |-> !found_q)
    else $error("status full with found set");
`endif

endmodule
